// ----- src/pjw_hash_pkg.sv -----
// Shared widths, register indexes and the byte fold function of the PJW bucket hash.
package pjw_hash_pkg;

  localparam int KEY_BYTE_W  = 8;
  localparam int BUCKET_W    = 16;
  localparam int HASH_W      = 28;
  localparam int KEY_LEN_W   = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_STEPS   = HASH_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN    = 1'd1;

  typedef logic [HASH_W-1:0]     hash_t;
  typedef logic [KEY_BYTE_W-1:0] key_byte_t;
  typedef logic [BUCKET_W-1:0]   bucket_t;
  typedef logic [KEY_LEN_W-1:0]  key_len_t;

  // One PJW step: shift in the byte, then fold the top nibble back down.
  function automatic hash_t fold_byte(hash_t h, key_byte_t b);
    logic [31:0] x;
    logic [3:0]  g;
    x = {h, 4'b0000} + {24'd0, b};
    g = x[31:28];
    x[7:4] = x[7:4] ^ g;
    return x[HASH_W-1:0];
  endfunction

endpackage

// ----- src/pjw_hash_if.sv -----
// Handshake interfaces for the key byte channel and the bucket channel.
interface pjw_key_if;
  import pjw_hash_pkg::*;
  logic      valid;
  logic      ready;
  key_byte_t key_byte;
  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

interface pjw_bucket_if;
  import pjw_hash_pkg::*;
  logic    valid;
  logic    ready;
  bucket_t bucket;
  modport source (output valid, output bucket, input ready);
  modport sink   (input valid, input bucket, output ready);
endinterface

// ----- src/pjw_bucket_hash_core.sv -----
// Top level of the PJW bucket hash: byte folding and a bit-serial remainder unit.
//
// Key bytes arrive one item at a time on in_key and are folded into a 28-bit
// PJW hash, one byte per cycle. With a key length of zero a zero byte ends the
// key and is not hashed; otherwise the key ends after the configured number of
// bytes (saturated to MAX_KEY_BYTES). At the end of a key the hash is reduced
// modulo table_size and the bucket is sent as one item on out_bucket.
// Throughput: a byte that does not end a key is taken every cycle. The byte
// that ends a key starts a restoring remainder unit that handles one dividend
// bit per cycle, and in_key is not ready until the remainder is done and the
// bucket has been loaded into the output register.
// The bucket sits in an output register, so the next key's bytes are taken
// while it waits. If the receiver still holds off when the next remainder is
// done, the unit holds its last step until the output register frees up.
// Configuration is written through cfg_we, cfg_index and cfg_wdata: index 0
// is table_size (zero acts as one bucket), index 1 is the key length.
// Synchronous active-low reset sets table_size to 1, the key length to 0, and
// clears the hash, the byte count and the output valid.
module pjw_bucket_hash_core
  import pjw_hash_pkg::*;
#(
  parameter int MAX_KEY_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pjw_key_if.sink               in_key,
  pjw_bucket_if.source          out_bucket
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic              state_r, state_nxt;
  bucket_t           table_size_r;
  key_len_t          key_len_r;
  hash_t             hash_r, hash_nxt;
  key_len_t          count_r, count_nxt;
  hash_t             div_q_r, div_q_nxt;
  bucket_t           rem_r, rem_nxt;
  bucket_t           mod_r, mod_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  bucket_t           out_bucket_r, out_bucket_nxt;

  key_len_t          len_eff;
  logic              in_fire;
  logic              key_end;
  hash_t             folded;
  logic [KEY_LEN_W:0] count_inc;
  logic [BUCKET_W:0] rem_shift;
  bucket_t           rem_step;
  logic              last_step;
  logic              slot_free;

  assign len_eff = (32'(key_len_r) > 32'(MAX_KEY_BYTES)) ?
                   KEY_LEN_W'(MAX_KEY_BYTES) : key_len_r;

  assign in_key.ready      = (state_r == ST_IDLE);
  assign in_fire           = in_key.valid && in_key.ready;
  assign folded            = fold_byte(hash_r, in_key.key_byte);
  assign count_inc         = {1'b0, count_r} + {{KEY_LEN_W{1'b0}}, 1'b1};
  assign key_end           = (len_eff == '0) ? (in_key.key_byte == '0)
                                             : (count_inc >= {1'b0, len_eff});

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign rem_shift = {rem_r, div_q_r[HASH_W-1]};
  assign rem_step  = (rem_shift >= {1'b0, mod_r}) ?
                     BUCKET_W'(rem_shift - {1'b0, mod_r}) : rem_shift[BUCKET_W-1:0];
  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));
  assign slot_free = !out_valid_r || out_bucket.ready;

  assign out_bucket.valid  = out_valid_r;
  assign out_bucket.bucket = out_bucket_r;

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    count_nxt      = count_r;
    div_q_nxt      = div_q_r;
    rem_nxt        = rem_r;
    mod_nxt        = mod_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;
    out_bucket_nxt = out_bucket_r;

    if (out_valid_r && out_bucket.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (key_end) begin
            div_q_nxt = (len_eff == '0) ? hash_r : folded;
            rem_nxt   = '0;
            mod_nxt   = (table_size_r == '0) ? BUCKET_W'(1) : table_size_r;
            step_nxt  = '0;
            hash_nxt  = '0;
            count_nxt = '0;
            state_nxt = ST_DIV;
          end else begin
            hash_nxt  = folded;
            count_nxt = (len_eff == '0) ? '0 : count_inc[KEY_LEN_W-1:0];
          end
        end
      end
      ST_DIV: begin
        if (!last_step) begin
          rem_nxt   = rem_step;
          div_q_nxt = {div_q_r[HASH_W-2:0], 1'b0};
          step_nxt  = step_r + STEP_W'(1);
        end else if (slot_free) begin
          out_bucket_nxt = rem_step;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      table_size_r <= BUCKET_W'(1);
      key_len_r    <= '0;
      hash_r       <= '0;
      count_r      <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TABLE_SIZE: table_size_r <= cfg_wdata[BUCKET_W-1:0];
          REG_KEY_LEN:    key_len_r    <= cfg_wdata[KEY_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    div_q_r      <= div_q_nxt;
    rem_r        <= rem_nxt;
    mod_r        <= mod_nxt;
    out_bucket_r <= out_bucket_nxt;
  end

`ifndef SYNTHESIS
  a_end_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && key_end) |=> (state_r == ST_DIV && hash_r == '0))
    else $error("key end did not start the remainder unit with a cleared hash");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < mod_r))
    else $error("partial remainder reached the modulus");

  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DIV && last_step))
    else $error("bucket appeared without a finished remainder");

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && last_step && slot_free) |=> (out_bucket_r < $past(mod_r)))
    else $error("bucket not below the table size");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the PJW bucket hash: directed script, random phases, bucket check.
module tb_top;
  import pjw_hash_pkg::*;

  localparam int MAX_KEY_BYTES = 512;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_BYTES   = 40;

  // A negative entry means a random pick for that phase.
  localparam int TS_PLAN [PHASES] = '{0, 65535, 1, -1, 65535, -1, -1, 256, -1, -1};
  localparam int KL_PLAN [PHASES] = '{3, 0, 1, 0, 1023, 7, 0, 16, -1, -1};

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   checked;
    bucket_t                bucket;
  } script_row_t;

  localparam int SCRIPT_ROWS = 31;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0000, 1'b1, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0000, 1'b1, 16'd0},
    '{ROW_WRITE, REG_TABLE_SIZE, 16'h0000, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0041, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0000, 1'b1, 16'd0},
    '{ROW_WRITE, REG_TABLE_SIZE, 16'hffff, 1'b0, 16'd0},
    '{ROW_WRITE, REG_KEY_LEN,    16'h0001, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b1, 16'd255},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0000, 1'b1, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0080, 1'b1, 16'd128},
    '{ROW_WRITE, REG_KEY_LEN,    16'hfc08, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0012, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0034, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0056, 1'b0, 16'd0},
    '{ROW_WRITE, REG_KEY_LEN,    16'h0002, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0078, 1'b0, 16'd0},
    '{ROW_WRITE, REG_KEY_LEN,    16'h0000, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0061, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0062, 1'b0, 16'd0},
    '{ROW_WRITE, REG_TABLE_SIZE, 16'h0007, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h0000, 1'b0, 16'd0},
    '{ROW_WRITE, REG_KEY_LEN,    16'h0008, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0},
    '{ROW_BYTE,  REG_TABLE_SIZE, 16'h00ff, 1'b0, 16'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pjw_key_if    key_ch();
  pjw_bucket_if bucket_ch();

  pjw_bucket_hash_core #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_key     (key_ch),
    .out_bucket (bucket_ch)
  );

  bucket_t               pending_buckets[$];
  int unsigned           mismatches = 0;
  int unsigned           cycles = 0;
  int                    burst_left = 0;

  // Shadow of the block's registers and running hash.
  logic [CFG_DATA_W-1:0] pred_table;
  key_len_t              pred_len;
  hash_t                 pred_hash;
  int unsigned           pred_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic hash_t fold_into_hash(hash_t h, key_byte_t b);
    logic [31:0] x;
    logic [31:0] top;
    x = {4'h0, h} << 4;
    x = x + 32'(b);
    top = x & 32'hf000_0000;
    if (top != 32'd0) begin
      x = x ^ (top >> 24);
      x = x ^ top;
    end
    return x[HASH_W-1:0];
  endfunction

  function automatic void predict_key_byte(input key_byte_t b, output bit ends,
                                           output bucket_t bkt);
    int unsigned lim;
    int unsigned modulus;
    lim = (pred_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : pred_len;
    ends = 1'b0;
    bkt = '0;
    if (lim == 0) begin
      // Terminated mode: a zero byte closes the key without being hashed.
      pred_count = 0;
      if (b == 8'd0) ends = 1'b1;
      else pred_hash = fold_into_hash(pred_hash, b);
    end else begin
      pred_hash = fold_into_hash(pred_hash, b);
      pred_count++;
      if (pred_count >= lim) ends = 1'b1;
    end
    if (ends) begin
      modulus = (pred_table == '0) ? 1 : pred_table;
      bkt = bucket_t'(pred_hash % modulus);
      pred_hash = '0;
      pred_count = 0;
    end
  endfunction

  // Stops sending and waits until every bucket in flight has come out.
  task automatic drain();
    @(negedge clk) key_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_TABLE_SIZE) pred_table = value;
    else pred_len = value[KEY_LEN_W-1:0];
  endtask

  task automatic send_key_byte(input key_byte_t b, input logic checked, input bucket_t lit);
    int      gap;
    bit      ends;
    bucket_t bkt;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk) key_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    key_ch.valid = 1'b1;
    key_ch.key_byte = b;
    do @(posedge clk); while (key_ch.ready !== 1'b1);
    predict_key_byte(b, ends, bkt);
    if (ends) pending_buckets.push_back(checked ? lit : bkt);
  endtask

  initial begin
    int               ts;
    int               kl;
    int               plen;
    int               klen;
    int               sent;
    int               pick;
    logic [CFG_DATA_W-1:0] word;
    rst_n = 1'b0;
    key_ch.valid = 1'b0;
    key_ch.key_byte = '0;
    cfg_we = 1'b0;
    cfg_index = REG_TABLE_SIZE;
    cfg_wdata = '0;
    pred_table = 16'd1;
    pred_len = '0;
    pred_hash = '0;
    pred_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].kind == ROW_WRITE) write_reg(SCRIPT[r].index, SCRIPT[r].value);
      else send_key_byte(SCRIPT[r].value[KEY_BYTE_W-1:0], SCRIPT[r].checked,
                         SCRIPT[r].bucket);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      ts = (TS_PLAN[ph] < 0) ? $urandom_range(2, 65535) : TS_PLAN[ph];
      kl = (KL_PLAN[ph] < 0) ? $urandom_range(0, 20) : KL_PLAN[ph];
      write_reg(REG_TABLE_SIZE, ts[CFG_DATA_W-1:0]);
      // Upper data bits are noise that the length register must drop.
      word = 16'($urandom);
      word[KEY_LEN_W-1:0] = kl[KEY_LEN_W-1:0];
      write_reg(REG_KEY_LEN, word);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if (kl == 0) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) klen = $urandom_range(150, 300);
          else if (pick < 3) klen = 0;
          else klen = $urandom_range(1, 12);
          repeat (klen) send_key_byte(key_byte_t'($urandom_range(1, 255)), 1'b0, '0);
          send_key_byte(8'd0, 1'b0, '0);
          sent += klen + 1;
        end else begin
          plen = (kl > MAX_KEY_BYTES) ? MAX_KEY_BYTES : kl;
          // Now and then a key is cut short and runs into the next one.
          if ($urandom_range(0, 9) == 0) plen = $urandom_range(1, plen);
          repeat (plen) send_key_byte(key_byte_t'($urandom_range(0, 255)), 1'b0, '0);
          sent += plen;
        end
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Receiver: stalls follow a random pattern that is reloaded, sometimes always ready.
  initial begin
    logic [15:0] pattern;
    int          pos;
    bucket_ch.ready = 1'b0;
    pattern = 16'hffff;
    pos = 0;
    forever begin
      @(negedge clk);
      if (pos % 48 == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end
      bucket_ch.ready = pattern[pos % 16];
      pos++;
    end
  end

  always @(posedge clk) begin : check_bucket
    bucket_t want;
    if (rst_n && bucket_ch.valid === 1'b1 && bucket_ch.ready === 1'b1) begin
      if (pending_buckets.size() == 0) begin
        $error("bucket: expected none, got %0d", bucket_ch.bucket);
        mismatches++;
      end else begin
        want = pending_buckets.pop_front();
        if (bucket_ch.bucket !== want) begin
          $error("bucket: expected %0d, got %0d", want, bucket_ch.bucket);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
src/pjw_hash_pkg.sv
src/pjw_hash_if.sv
src/pjw_bucket_hash_core.sv
bench/tb_top.sv
